// ===== rtl/annex_b_nal_splitter_defines.svh =====
// ----------------------------------------------------------------------------
// Annex B unit splitter: assertion macros
// Shared property wrappers. They sample on clk and are disabled under rst.
// ----------------------------------------------------------------------------
`ifndef ANNEX_B_NAL_SPLITTER_DEFINES_SVH
`define ANNEX_B_NAL_SPLITTER_DEFINES_SVH

// Condition must hold at every sampled edge out of reset.
`define ANNB_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("annex_b_nal_splitter: invariant violated");

// Consequent must hold in the same cycle as the antecedent.
`define ANNB_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("annex_b_nal_splitter: implication violated");

`endif

// ===== rtl/annb_pkg.sv =====
// ----------------------------------------------------------------------------
// Annex B unit splitter package
// Shared types, constants and the start code detector.
// ----------------------------------------------------------------------------
`default_nettype none

package annb_pkg;

  localparam int HOLD_DEPTH = 5;
  localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONE  = 8'h01;

  localparam logic [1:0] KIND_BODY    = 2'd0;
  localparam logic [1:0] KIND_RAW     = 2'd1;
  localparam logic [1:0] KIND_DISCARD = 2'd2;

  // Byte class as seen by the start code detector
  typedef enum logic [1:0] {
    CLS_OTHER,
    CLS_ZERO,
    CLS_ONE
  } cls_t;

  typedef struct packed {
    logic [7:0] data;
    cls_t       cls;
  } tag_byte_t;

  localparam int TB_W = $bits(tag_byte_t);

  // Entry 0 is the front of the hold queue
  typedef tag_byte_t [HOLD_DEPTH-1:0] hold_t;

  typedef struct packed {
    tag_byte_t tb;
    logic      last;
  } fifo_entry_t;

  typedef struct packed {
    logic       valid;
    fifo_entry_t entry;
  } front_head_t;

  typedef struct packed {
    logic [CNT_W-1:0] hold_cnt;
    logic [1:0]       code_pos;
    logic             idle;
  } back_status_t;

  // Start code at a queue position: none, undecided yet, short or long
  typedef enum logic [1:0] {
    CODE_NONE,
    CODE_WAIT,
    CODE_3,
    CODE_4
  } code_t;

  function automatic cls_t classify(input logic [7:0] b);
    cls_t c;
    if (b == BYTE_ZERO) begin
      c = CLS_ZERO;
    end else if (b == BYTE_ONE) begin
      c = CLS_ONE;
    end else begin
      c = CLS_OTHER;
    end
    return c;
  endfunction

  function automatic code_t code_at(input hold_t q, input logic [CNT_W-1:0] n,
                                    input logic j, input logic ended);
    logic [CNT_W-1:0] base;
    logic [CNT_W-1:0] avail;
    code_t            undecided;
    code_t            c;
    base      = {{(CNT_W-1){1'b0}}, j};
    avail     = (n > base) ? n - base : '0;
    undecided = ended ? CODE_NONE : CODE_WAIT;
    if (avail == CNT_W'(0)) begin
      c = undecided;
    end else if (q[base].cls != CLS_ZERO) begin
      c = CODE_NONE;
    end else if (avail < CNT_W'(2)) begin
      c = undecided;
    end else if (q[base + CNT_W'(1)].cls != CLS_ZERO) begin
      c = CODE_NONE;
    end else if (avail < CNT_W'(3)) begin
      c = undecided;
    end else if (q[base + CNT_W'(2)].cls == CLS_OTHER) begin
      c = CODE_NONE;
    end else if (avail < CNT_W'(4)) begin
      c = undecided;
    end else if (q[base + CNT_W'(2)].cls == CLS_ONE) begin
      c = CODE_3;
    end else if (q[base + CNT_W'(3)].cls == CLS_ONE) begin
      c = CODE_4;
    end else begin
      c = CODE_NONE;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/annb_front.sv =====
// ----------------------------------------------------------------------------
// Annex B unit splitter: front end
// Accepts packet bytes, tags each as zero, one or other, and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module annb_front
  import annb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        packet_end,
  output front_head_t      head,
  input  wire logic        head_take
);

  fifo_entry_t             mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr;
  logic [FIFO_PTR_W-1:0]   rd_ptr;
  logic [FIFO_CNT_W-1:0]   count;
  logic                    push;
  logic                    pop;

  assign in_stall   = (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign push       = in_valid && !in_stall;
  assign pop        = head_take && (count != '0);
  assign head.valid = (count != '0);
  assign head.entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{tb: '{data: in_byte, cls: classify(in_byte)}, last: packet_end};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + FIFO_CNT_W'(1);
        2'b01:   count <= count - FIFO_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/annb_back.sv =====
// ----------------------------------------------------------------------------
// Annex B unit splitter: back end
// Holds back up to five bytes, resolves start codes and drives results.
// ----------------------------------------------------------------------------
`default_nettype none

module annb_back
  import annb_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire front_head_t  head,
  output logic              head_take,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [7:0]        out_byte,
  output logic [1:0]        kind,
  output logic              unit_last,
  output back_status_t      status
);

  hold_t             hold;
  logic [CNT_W-1:0]  cnt;
  logic              body_seen;
  logic              in_unit;
  logic              prov_any;
  logic              cur_end;
  logic [1:0]        code_pos;

  code_t             cur_len;
  code_t             cur_nx;
  logic              idle;
  logic              out_ready;
  logic              active;

  hold_t             qe;
  logic [CNT_W-1:0]  ne;
  logic              ee;
  code_t             len;
  code_t             nx;
  logic [1:0]        code_last_pos;

  logic              emit;
  logic [7:0]        emit_byte;
  logic [1:0]        emit_kind;
  logic              emit_last;
  logic [CNT_W-1:0]  pop;
  hold_t             hold_next;
  logic [CNT_W-1:0]  cnt_next;
  logic              body_seen_next;
  logic              in_unit_next;
  logic              prov_any_next;
  logic [1:0]        code_pos_next;

  // The step is over when the queue is empty or the front cannot be decided yet
  always_comb begin
    cur_len = code_at(hold, cnt, 1'b0, cur_end);
    cur_nx  = code_at(hold, cnt, 1'b1, cur_end);
    idle    = (cnt == '0) || (cur_len == CODE_WAIT) ||
              ((cur_len == CODE_NONE) && in_unit && (cur_nx == CODE_WAIT));
  end

  assign out_ready = !out_valid || !out_stall;
  assign active    = out_ready && (!idle || head.valid);
  assign head_take = out_ready && idle && head.valid;

  assign status = '{hold_cnt: cnt, code_pos: code_pos, idle: idle};

  always_comb begin
    qe = hold;
    ne = cnt;
    ee = cur_end;
    if (idle) begin
      qe[cnt] = head.entry.tb;
      ne      = cnt + CNT_W'(1);
      ee      = head.entry.last;
    end
    len           = code_at(qe, ne, 1'b0, ee);
    nx            = code_at(qe, ne, 1'b1, ee);
    code_last_pos = (len == CODE_4) ? 2'd3 : 2'd2;

    emit           = 1'b0;
    emit_byte      = qe[0].data;
    emit_kind      = KIND_RAW;
    emit_last      = 1'b0;
    pop            = '0;
    body_seen_next = body_seen;
    in_unit_next   = in_unit;
    prov_any_next  = prov_any;
    code_pos_next  = code_pos;

    case (len)
      CODE_3, CODE_4: begin
        if (!body_seen) begin
          // pass the code bytes out one by one as provisional bytes
          emit      = 1'b1;
          emit_byte = qe[{1'b0, code_pos}].data;
          emit_kind = KIND_RAW;
          emit_last = ee && (({1'b0, code_pos} + CNT_W'(1)) == ne);
          if (code_pos == code_last_pos) begin
            pop           = {1'b0, code_last_pos} + CNT_W'(1);
            in_unit_next  = 1'b1;
            prov_any_next = 1'b1;
            code_pos_next = 2'd0;
          end else begin
            code_pos_next = code_pos + 2'd1;
          end
        end else begin
          pop          = {1'b0, code_last_pos} + CNT_W'(1);
          in_unit_next = 1'b1;
        end
      end
      CODE_NONE: begin
        if (in_unit) begin
          if (nx != CODE_WAIT) begin
            body_seen_next = 1'b1;
            if (!body_seen && prov_any) begin
              // cancel the provisional bytes; the body byte is emitted after the marker
              emit      = 1'b1;
              emit_byte = BYTE_ZERO;
              emit_kind = KIND_DISCARD;
            end else begin
              emit      = 1'b1;
              emit_kind = KIND_BODY;
              emit_last = (nx == CODE_3) || (nx == CODE_4) || (ee && (ne == CNT_W'(1)));
              pop       = CNT_W'(1);
            end
          end
        end else begin
          emit          = 1'b1;
          emit_kind     = KIND_RAW;
          emit_last     = ee && (ne == CNT_W'(1));
          prov_any_next = 1'b1;
          pop           = CNT_W'(1);
        end
      end
      default: begin
        // undecided: hold the pushed byte and wait for more
      end
    endcase

    cnt_next = ne - pop;
    case (pop)
      CNT_W'(1): hold_next = qe >> TB_W;
      CNT_W'(3): hold_next = qe >> (3 * TB_W);
      CNT_W'(4): hold_next = qe >> (4 * TB_W);
      default:   hold_next = qe;
    endcase
  end

  always_ff @(posedge clk) begin
    if (active) begin
      hold <= hold_next;
    end
    if (out_ready && active && emit) begin
      out_byte  <= emit_byte;
      kind      <= emit_kind;
      unit_last <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      body_seen <= 1'b0;
      in_unit   <= 1'b0;
      prov_any  <= 1'b0;
      cur_end   <= 1'b0;
      code_pos  <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid <= active && emit;
      end
      if (active) begin
        cnt      <= cnt_next;
        code_pos <= code_pos_next;
        if (ee && (cnt_next == '0)) begin
          // packet fully flushed: drop per-packet flags
          body_seen <= 1'b0;
          in_unit   <= 1'b0;
          prov_any  <= 1'b0;
          cur_end   <= 1'b0;
        end else begin
          body_seen <= body_seen_next;
          in_unit   <= in_unit_next;
          prov_any  <= prov_any_next;
          cur_end   <= ee;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/annex_b_nal_splitter.sv =====
// ----------------------------------------------------------------------------
// Annex B unit splitter, top level
// Splits a byte stream at Annex B start codes, marking unit ends and
// cancelling provisional bytes once the first unit body byte appears.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_stall    in_byte, packet_end
//   out      source     out_valid / out_stall  out_byte, kind, unit_last
//
// One byte per clock in steady state and one back-end queue step a cycle while
// the output is not stalled. Start code bytes before the first body byte pass one
// by one, a discard marker precedes that byte if any went out, and a later start
// code leaves the queue whole. At packet end up to four held bytes flush at one
// per cycle unless the output stalls. No clearing pass at reset.
// Either side may stall freely; a four-entry queue decouples front and back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "annex_b_nal_splitter_defines.svh"

module annex_b_nal_splitter
  import annb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        packet_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic [1:0]       kind,
  output logic             unit_last
);

  front_head_t   head;
  logic          head_take;
  back_status_t  back_status;

  annb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .packet_end (packet_end),
    .head       (head),
    .head_take  (head_take)
  );

  annb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_take  (head_take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .kind       (kind),
    .unit_last  (unit_last),
    .status     (back_status)
  );

  `ANNB_ASSERT_ALWAYS(a_hold_bound, back_status.hold_cnt <= CNT_W'(HOLD_DEPTH))
  `ANNB_ASSERT_IMPLIES(a_idle_code_pos, back_status.idle, back_status.code_pos == 2'd0)
  `ANNB_ASSERT_IMPLIES(a_marker_empty, out_valid && (kind == KIND_DISCARD), (out_byte == BYTE_ZERO) && !unit_last)

endmodule

`default_nettype wire

// ===== sim/annex_b_nal_splitter_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Annex B unit splitter checker
// Watches the byte and result channels and keeps its own model of the start
// code search. It compares each result transaction with the oldest predicted
// one, field by field, and hands the mismatch tally and the number of
// predictions still waiting to the testbench top.
// ----------------------------------------------------------------------------
module annex_b_nal_splitter_checker
  import annb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       packet_end,
  input  wire logic       out_valid,
  input  wire logic       out_stall,
  input  wire logic [7:0] out_byte,
  input  wire logic [1:0] kind,
  input  wire logic       unit_last,
  output int              mismatches,
  output int              outstanding
);

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       last;
  } split_byte_t;

  split_byte_t due_q[$];
  logic [7:0]  held_q[$];
  bit          body_started;
  bit          code_passed;
  bit          raw_emitted;

  // Start code beginning at held position pos, or CODE_WAIT while more bytes could decide it
  function automatic code_t code_after(input int pos, input logic ended);
    code_t undecided;
    int    avail;
    undecided = ended ? CODE_NONE : CODE_WAIT;
    avail     = held_q.size() - pos;
    if (avail < 1) return undecided;
    if (held_q[pos] != BYTE_ZERO) return CODE_NONE;
    if (avail < 2) return undecided;
    if (held_q[pos + 1] != BYTE_ZERO) return CODE_NONE;
    if (avail < 3) return undecided;
    if (held_q[pos + 2] != BYTE_ZERO && held_q[pos + 2] != BYTE_ONE) return CODE_NONE;
    if (avail < 4) return undecided;
    if (held_q[pos + 2] == BYTE_ONE) return CODE_3;
    return (held_q[pos + 3] == BYTE_ONE) ? CODE_4 : CODE_NONE;
  endfunction

  task automatic note(input logic [7:0] data, input logic [1:0] k, input logic last);
    split_byte_t e;
    e.data = data;
    e.kind = k;
    e.last = last;
    due_q = {due_q, e};
  endtask

  task automatic split_byte(input logic [7:0] b, input logic ended);
    code_t lead;
    code_t follow;
    int    len;
    int    k;
    logic  tail;
    if (held_q.size() < HOLD_DEPTH) held_q = {held_q, b};
    while (held_q.size() > 0) begin
      lead = code_after(0, ended);
      if (lead == CODE_WAIT) break;
      if (lead == CODE_3 || lead == CODE_4) begin
        len = (lead == CODE_3) ? 3 : 4;
        // codes before the first body byte still leave as provisional bytes
        if (!body_started) begin
          for (k = 0; k < len; k++) begin
            note(held_q[k], KIND_RAW, ended && (k + 1 == held_q.size()));
          end
          raw_emitted = 1'b1;
        end
        repeat (len) void'(held_q.pop_front());
        code_passed = 1'b1;
      end else if (code_passed) begin
        follow = code_after(1, ended);
        if (follow == CODE_WAIT) break;
        tail = (follow == CODE_3 || follow == CODE_4) || (ended && held_q.size() == 1);
        if (!body_started) begin
          if (raw_emitted) note(BYTE_ZERO, KIND_DISCARD, 1'b0);
          body_started = 1'b1;
        end
        note(held_q[0], KIND_BODY, tail);
        void'(held_q.pop_front());
      end else begin
        note(held_q[0], KIND_RAW, ended && held_q.size() == 1);
        raw_emitted = 1'b1;
        void'(held_q.pop_front());
      end
    end
    if (ended) begin
      held_q.delete();
      body_started = 1'b0;
      code_passed  = 1'b0;
      raw_emitted  = 1'b0;
    end
  endtask

  always @(posedge clk) begin : watch
    int          bad;
    split_byte_t want;
    bad = 0;
    if (rst) begin
      held_q.delete();
      due_q.delete();
      body_started = 1'b0;
      code_passed  = 1'b0;
      raw_emitted  = 1'b0;
      mismatches  <= 0;
      outstanding <= 0;
    end else begin
      if (in_valid && !in_stall) split_byte(in_byte, packet_end);
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          $error("unexpected transaction: out_byte %02h kind %0d unit_last %0b",
                 out_byte, kind, unit_last);
          bad++;
        end else begin
          want = due_q.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected %02h, got %02h", want.data, out_byte);
            bad++;
          end
          if (kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, kind);
            bad++;
          end
          if (unit_last !== want.last) begin
            $error("unit_last: expected %0b, got %0b", want.last, unit_last);
            bad++;
          end
        end
      end
      mismatches  <= mismatches + bad;
      outstanding <= due_q.size();
    end
  end

endmodule

// ===== sim/annex_b_nal_splitter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Annex B unit splitter testbench
// Feeds packets to the splitter: a few hand-built ones for the corner cases,
// then random packets, mostly made of start codes and bodies, some of them
// plain noise. Both channels idle at random. The checker beside the block
// does the prediction; this module only drives and gives the verdict.
// ----------------------------------------------------------------------------
module annex_b_nal_splitter_test
  import annb_pkg::*;
();

  localparam int RANDOM_ITEMS = 480;
  localparam int CYCLE_LIMIT  = 600000;

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       in_valid   = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte    = 8'h00;
  logic       packet_end = 1'b0;
  logic       out_valid;
  logic       out_stall  = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       unit_last;

  int         mismatches;
  int         outstanding;
  int         items_sent = 0;
  int         random_from;
  bit         tx_steady  = 1'b0;
  bit         draining   = 1'b0;
  int         stall_left = 0;
  logic [8:0] rx_phase   = '0;
  int         rx_roll;
  logic [7:0] pkt[$];

  annex_b_nal_splitter DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .packet_end (packet_end),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .kind       (kind),
    .unit_last  (unit_last)
  );

  annex_b_nal_splitter_checker split_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .packet_end  (packet_end),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .kind        (kind),
    .unit_last   (unit_last),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver: short and long stalls, with a calm quarter of each rx_phase wrap in which no new stall starts
  always @(posedge clk) begin
    rx_phase <= rx_phase + 1'b1;
    if (rst || draining) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (rx_phase[8:7] == 2'b11 || rx_roll < 65) begin
        out_stall <= 1'b0;
      end else if (rx_roll < 95) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 3);
      end else begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(8, 30);
      end
    end
  end

  // Lean towards the bytes that make up start codes
  function automatic logic [7:0] pick_byte();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) return BYTE_ZERO;
    if (roll < 35) return BYTE_ONE;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (tx_steady || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 25);
  endfunction

  task automatic append_byte(input logic [7:0] b);
    pkt = {pkt, b};
  endtask

  task automatic ship_packet();
    int i;
    int gap;
    for (i = 0; i < pkt.size(); i++) begin
      gap = pick_gap();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid   <= 1'b1;
      in_byte    <= pkt[i];
      packet_end <= (i == pkt.size() - 1);
      @(posedge clk);
      while (in_stall) @(posedge clk);
      items_sent++;
    end
    pkt.delete();
  endtask

  // Leading junk, then units of optional extra zeros, a code and a body
  task automatic build_coded_packet();
    int units;
    int body;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) append_byte(pick_byte());
    end
    units = $urandom_range(1, 4);
    repeat (units) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 2)) append_byte(BYTE_ZERO);
      end
      if ($urandom_range(0, 1) == 1) append_byte(BYTE_ZERO);
      append_byte(BYTE_ZERO);
      append_byte(BYTE_ZERO);
      append_byte(BYTE_ONE);
      body = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
      repeat (body) append_byte(pick_byte());
    end
    // short code right at the packet end must stay in the unit
    if ($urandom_range(0, 9) == 0) begin
      append_byte(BYTE_ZERO);
      append_byte(BYTE_ZERO);
      append_byte(BYTE_ONE);
    end
  endtask

  initial begin
    int roll;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // long code then a single top-value body byte
    pkt = '{8'h00, 8'h00, 8'h00, 8'h01, 8'hFF};
    ship_packet();
    // empty unit between two short codes
    pkt = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'h80};
    ship_packet();
    // lone zero: the whole packet passes as a raw byte
    pkt = '{8'h00};
    ship_packet();
    // short code as the final bytes is no code
    pkt = '{8'hAA, 8'h00, 8'h00, 8'h01};
    ship_packet();
    // extra leading zero, body, then a short code and another unit
    pkt = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h7F, 8'h00, 8'h00, 8'h01, 8'h01};
    ship_packet();

    random_from = items_sent;
    while (items_sent < random_from + RANDOM_ITEMS) begin
      tx_steady = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 9);
      if (roll < 7) begin
        build_coded_packet();
      end else if (roll < 9) begin
        repeat ($urandom_range(1, 12)) append_byte(pick_byte());
      end else begin
        repeat ($urandom_range(1, 3)) append_byte(pick_byte());
      end
      ship_packet();
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    draining <= 1'b1;
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
